[sv/assert_macros.svh]
// assertion macros used by next_lexicographic_permutation
// no dependencies; expects clk and rst in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/nlp_pkg.sv]
// shared types and constants for the next-permutation engine
// no dependencies
`default_nettype none

package nlp_pkg;

  localparam int MAX_LEN_DEF    = 16;
  localparam int ELEM_WIDTH_DEF = 8;

  // fixed port widths
  localparam int LEN_W  = 5;
  localparam int SLOT_W = 4;
  localparam int ELEM_W = 8;
  localparam int POS_W  = 4;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ROTATE,
    OP_PLACE,
    OP_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/nlp_cell.sv]
// one element slot of the permutation row
// depends on nlp_pkg
`default_nettype none

module nlp_cell import nlp_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int POS        = 0
) (
  input  wire logic                         clk,
  input  wire cell_ctrl_t                   ctrl,
  input  wire logic [$clog2(MAX_LEN+1)-1:0] n_act,
  input  wire logic [$clog2(MAX_LEN+1)-1:0] sort_lo,
  input  wire logic [$clog2(MAX_LEN)-1:0]   a_idx,
  input  wire logic [ELEM_WIDTH-1:0]        a_data,
  input  wire logic [$clog2(MAX_LEN)-1:0]   b_idx,
  input  wire logic [ELEM_WIDTH-1:0]        b_data,
  input  wire logic [ELEM_WIDTH-1:0]        left_val,
  input  wire logic [ELEM_WIDTH-1:0]        right_val,
  input  wire logic [ELEM_WIDTH-1:0]        head_val,
  output logic      [ELEM_WIDTH-1:0]        val
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  localparam logic [IDX_W-1:0] POS_I    = IDX_W'(POS);
  localparam logic [CNT_W-1:0] POS_C    = CNT_W'(POS);
  localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(POS + 1);
  localparam logic             POS_ODD  = 1'((POS % 2));

  logic [ELEM_WIDTH-1:0] val_next;
  logic                  pair_right;
  logic                  pair_left;

  // pair (pos, pos+1) and pair (pos-1, pos) of the odd-even exchange
  assign pair_right = (ctrl.phase == POS_ODD) && (POS_C >= sort_lo) && (POS_NEXT < n_act);
  assign pair_left  = (ctrl.phase != POS_ODD) && (POS_C > sort_lo) && (POS_C < n_act);

  always_comb begin
    val_next = val;
    unique case (ctrl.op)
      OP_HOLD: begin
        val_next = val;
      end
      OP_LOAD: begin
        if (a_idx == POS_I) val_next = a_data;
      end
      OP_PLACE: begin
        if (a_idx == POS_I) begin
          val_next = a_data;
        end else if (b_idx == POS_I) begin
          val_next = b_data;
        end
      end
      OP_ROTATE: begin
        if (POS_NEXT == n_act) begin
          val_next = head_val;
        end else if (POS_C < n_act) begin
          val_next = right_val;
        end
      end
      OP_SORT: begin
        if (pair_right && (val > right_val)) begin
          val_next = right_val;
        end else if (pair_left && (left_val > val)) begin
          val_next = left_val;
        end
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

`default_nettype wire

[sv/next_lexicographic_permutation.sv]
// step: from the start beat the cell row runs the scan rotation, the place step (skipped
//   on a wrap), the sort rounds and the emit rotation, n = active length; busy stays
//   high until the emit rotation has ended
// load: one beat per cycle, no results, busy stays low
// results: n beats on consecutive cycles; the receiver cannot stall
// reset: synchronous rst clears control and sets length_in_use to 16; element cells are
//   not cleared and hold garbage until loaded
// depends on nlp_pkg, nlp_cell and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module next_lexicographic_permutation import nlp_pkg::*; #(
  parameter int MAX_LEN    = MAX_LEN_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command beat
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              command,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [ELEM_W-1:0] element,
  // length register
  input  wire logic              cfg_write,
  input  wire logic [LEN_W-1:0]  cfg_wdata,
  // result beats
  output logic                   result_valid,
  output logic [POS_W-1:0]       position,
  output logic [ELEM_W-1:0]      value_out,
  output logic                   wrapped,
  output logic                   last_of_run
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  state_t state, state_next;

  logic [LEN_W-1:0]      length_in_use;
  logic [CNT_W-1:0]      n_act;      // clamped length, 1..MAX_LEN
  logic [CNT_W-1:0]      n_cur;      // length captured for this step
  logic [CNT_W-1:0]      cnt;        // rotation step or sort round
  logic                  last_cnt;

  // pivot tracking, filled during the scan rotation
  logic                  piv_found;
  logic [IDX_W-1:0]      piv_pos;
  logic [ELEM_WIDTH-1:0] piv_val;
  logic [IDX_W-1:0]      succ_pos;
  logic [ELEM_WIDTH-1:0] succ_val;
  logic [CNT_W-1:0]      sort_lo;

  logic                  step_go;
  logic                  load_go;
  logic                  slot_ok;
  logic                  ascent;
  logic                  larger;

  // cell row
  cell_ctrl_t            ctrl;
  logic [IDX_W-1:0]      a_idx;
  logic [ELEM_WIDTH-1:0] a_data;
  logic [ELEM_WIDTH-1:0] cell_val [MAX_LEN];

  assign busy     = (state != ST_IDLE);
  assign step_go  = start && !busy && (command == CMD_STEP);
  assign slot_ok  = (32'(slot) < MAX_LEN);
  assign load_go  = start && !busy && (command == CMD_LOAD) && slot_ok;
  assign last_cnt = (cnt == (n_cur - CNT_W'(1)));

  // during the scan, cell 0 holds element cnt and cell 1 holds element cnt+1
  assign ascent = !last_cnt && (cell_val[0] < cell_val[1]);
  assign larger = piv_found && (cell_val[0] > piv_val);

  // length of zero acts as one, above the row size acts as the row size
  always_comb begin
    if (length_in_use == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(length_in_use) > MAX_LEN) begin
      n_act = CNT_W'(MAX_LEN);
    end else begin
      n_act = CNT_W'(length_in_use);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (step_go) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        // no ascent can appear on the last scan step, so piv_found is final here
        if (last_cnt) state_next = piv_found ? ST_PLACE : ST_SORT;
      end
      ST_PLACE: begin
        state_next = ST_SORT;
      end
      ST_SORT: begin
        if (last_cnt) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (last_cnt) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // cell row control
  always_comb begin
    ctrl.phase = cnt[0];
    ctrl.op    = OP_HOLD;
    unique case (state)
      ST_IDLE:  ctrl.op = load_go ? OP_LOAD : OP_HOLD;
      ST_SCAN:  ctrl.op = OP_ROTATE;
      ST_PLACE: ctrl.op = OP_PLACE;
      ST_SORT:  ctrl.op = OP_SORT;
      ST_EMIT:  ctrl.op = OP_ROTATE;
      default:  ctrl.op = OP_HOLD;
    endcase
  end

  // pivot gets the successor value; loads use the same port
  assign a_idx  = (state == ST_PLACE) ? piv_pos  : IDX_W'(slot);
  assign a_data = (state == ST_PLACE) ? succ_val : ELEM_WIDTH'(element);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      piv_found     <= 1'b0;
      result_valid  <= 1'b0;
      length_in_use <= LEN_RESET;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_EMIT);
      if (cfg_write) length_in_use <= cfg_wdata;
      if ((state_next != state) || (state == ST_IDLE)) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
      if (step_go) begin
        piv_found <= 1'b0;
      end else if ((state == ST_SCAN) && ascent) begin
        piv_found <= 1'b1;
      end
    end
  end

  // pivot data and result beat
  always_ff @(posedge clk) begin
    if (step_go) begin
      n_cur   <= n_act;
      sort_lo <= '0;
    end
    if (state == ST_SCAN) begin
      if (ascent) begin
        // rightmost ascent so far; its right neighbor is the first successor candidate
        piv_pos  <= IDX_W'(cnt);
        piv_val  <= cell_val[0];
        succ_pos <= IDX_W'(cnt + CNT_W'(1));
        succ_val <= cell_val[1];
        sort_lo  <= cnt + CNT_W'(1);
      end else if (larger) begin
        // rightmost element above the pivot
        succ_pos <= IDX_W'(cnt);
        succ_val <= cell_val[0];
      end
    end
    if (state == ST_EMIT) begin
      position    <= POS_W'(cnt);
      value_out   <= ELEM_W'(cell_val[0]);
      wrapped     <= !piv_found;
      last_of_run <= last_cnt;
    end
  end

  // row of cells; ends wrap around, the active length decides where the ring closes
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    nlp_cell #(
      .MAX_LEN    (MAX_LEN),
      .ELEM_WIDTH (ELEM_WIDTH),
      .POS        (k)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .n_act     (n_cur),
      .sort_lo   (sort_lo),
      .a_idx     (a_idx),
      .a_data    (a_data),
      .b_idx     (succ_pos),
      .b_data    (piv_val),
      .left_val  (cell_val[(k + MAX_LEN - 1) % MAX_LEN]),
      .right_val (cell_val[(k + 1) % MAX_LEN]),
      .head_val  (cell_val[0]),
      .val       (cell_val[k])
    );
  end

  // checks
  `ASSERT_NEXT(a_run_ends, result_valid && last_of_run, !result_valid)
  `ASSERT_NEXT(a_run_steps, result_valid && !last_of_run, result_valid && (position == POS_W'($past(position) + 1'b1)))
  `ASSERT_IMPL(a_place_has_pivot, state == ST_PLACE, piv_found)
  `ASSERT_IMPL(a_idle_quiet, !busy && !$past(busy), !result_valid)

endmodule

`default_nettype wire
